// File: hw/rtl/chsbc_pkg.sv
// Package with the shared types, codes and byte functions of the chained substitution cipher.
`default_nettype none

package chsbc_pkg;

    // Operation codes carried in the func field of an input transaction.
    typedef enum logic [1:0] {
        FUNC_KEY_LOAD = 2'd0,
        FUNC_TAB_LOAD = 2'd1,
        FUNC_DATA     = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    // Cipher direction held in the mode register.
    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } mode_t;

    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned ADDR_W     = 12;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 8;
    localparam logic [BYTE_W-1:0] TRADE_OFFSET = 8'd128;

    // Reverse the bit order of a byte.
    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    // Trade function applied to the first byte of a message.
    function automatic logic [BYTE_W-1:0] trade(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] a;
        a = v + TRADE_OFFSET;
        return rev8(a) + TRADE_OFFSET;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chained_sbox_byte_cipher_top.sv
// Top level of the chained substitution byte cipher with its key store and table memories.
//
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: func[1:0], addr[13:2], value[21:14], zero pad; tlast: last
// m_axis    out  tdata: out_byte[7:0]; tlast: out_last
// cfg       in   cfg_we, cfg_wdata: mode
//
// Decrypt: one transaction per cycle; key store and table are read at acceptance
// into read registers, then the byte goes to the output register. Encrypt: a later
// byte takes the second stage's table read, a first byte skips it; the chained output
// feeds the next key read after it. The memories are not cleared after reset.
// A stall on m_axis holds the result register and, through it, the input side.
`default_nettype none

module chained_sbox_byte_cipher_top
    import chsbc_pkg::*;
#(
    parameter int unsigned KEY_DEPTH = 4096
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // func[1:0], addr[13:2], value[21:14]
    input  wire logic                  s_axis_tlast,   // last
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // out_byte[7:0]
    output logic                       m_axis_tlast,   // out_last
    // Mode register
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_wdata
);

    localparam int unsigned POS_W = $clog2(KEY_DEPTH);

    // Unpacked input fields.
    func_t             in_func;
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_value;

    // Control and state registers.
    mode_t             mode_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] chain_reg;
    logic [BYTE_W-1:0] chain_next;

    // First stage: a data byte whose memory reads are in flight.
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [BYTE_W-1:0] s1_x_reg;

    // Second stage: an encrypted byte waiting on its second table read.
    logic              s2_valid_reg;
    logic              s2_last_reg;

    // Output register.
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    // Memories and their registered read data.
    logic [BYTE_W-1:0] key_mem [KEY_DEPTH];
    logic [BYTE_W-1:0] tab_mem [256];
    logic [BYTE_W-1:0] key_chain_rd_reg;
    logic [BYTE_W-1:0] key_pos_rd_reg;
    logic [BYTE_W-1:0] tab_rd_reg;

    // Handshake and datapath helpers.
    logic              in_fire;
    logic              data_fire;
    logic              key_wr;
    logic              tab_wr;
    logic              enc;
    logic              out_free;
    logic              s1_to_out;
    logic              s1_to_s2;
    logic              s1_move;
    logic              s2_move;
    logic              out_load;
    logic [BYTE_W-1:0] key_sum;
    logic [BYTE_W-1:0] s1_y;
    logic [BYTE_W-1:0] y_out;
    logic              last_out;
    logic [BYTE_W-1:0] tab_rd_addr;
    logic              tab_rd_en;

    assign in_func  = func_t'(s_axis_tdata[1:0]);
    assign in_addr  = s_axis_tdata[13:2];
    assign in_value = s_axis_tdata[21:14];

    assign enc = (mode_reg == MODE_ENCRYPT);

    // Pipeline movement. Encryption holds one byte at a time, as the chain byte is
    // the output; decryption chains on the input and streams.
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s1_to_out = s1_valid_reg && (!enc || s1_first_reg);
    assign s1_to_s2  = s1_valid_reg && enc && !s1_first_reg && !s2_valid_reg;
    assign s1_move   = s1_to_out ? out_free : s1_to_s2;
    assign s2_move   = s2_valid_reg && out_free;
    assign out_load  = (s1_to_out && out_free) || s2_move;

    assign s_axis_tready = enc ? (!s1_valid_reg && !s2_valid_reg)
                               : (!s1_valid_reg || s1_move);

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign data_fire = in_fire && (in_func == FUNC_DATA);
    assign key_wr    = in_fire && (in_func == FUNC_KEY_LOAD)
                       && (32'(in_addr) < 32'(KEY_DEPTH));
    assign tab_wr    = in_fire && (in_func == FUNC_TAB_LOAD);

    // Key stream byte and the result of the first stage.
    assign key_sum = key_chain_rd_reg + key_pos_rd_reg;

    always_comb
    begin
        priority if (enc)
        begin
            s1_y = tab_rd_reg;
        end
        else if (s1_first_reg)
        begin
            s1_y = trade(tab_rd_reg);
        end
        else
        begin
            s1_y = tab_rd_reg ^ key_sum;
        end
    end

    assign y_out    = s2_valid_reg ? tab_rd_reg : s1_y;
    assign last_out = s2_valid_reg ? s2_last_reg : s1_last_reg;

    // Table read address: the second encrypt read wins, else the accepted byte or its trade.
    always_comb
    begin
        priority if (s1_to_s2)
        begin
            tab_rd_addr = s1_x_reg ^ key_sum;
        end
        else if (enc && (pos_reg == '0))
        begin
            tab_rd_addr = trade(in_value);
        end
        else
        begin
            tab_rd_addr = in_value;
        end
    end
    assign tab_rd_en = s1_to_s2 || data_fire;

    // Position steps per data byte, wraps at the key depth and restarts after last.
    always_comb
    begin
        pos_next = pos_reg;
        if (data_fire)
        begin
            if (s_axis_tlast || (32'(pos_reg) == 32'(KEY_DEPTH - 1)))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    // Chain byte: the input byte when decrypting, the output byte when encrypting.
    always_comb
    begin
        chain_next = chain_reg;
        if (data_fire && !enc)
        begin
            chain_next = in_value;
        end
        else if (out_load && enc)
        begin
            chain_next = y_out;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENCRYPT;
            pos_reg       <= '0;
            chain_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= mode_t'(cfg_wdata);
            end
            pos_reg   <= pos_next;
            chain_reg <= chain_next;
            if (data_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_to_s2)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_move)
            begin
                s2_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the stages.
    always_ff @(posedge clk)
    begin
        if (data_fire)
        begin
            s1_first_reg <= (pos_reg == '0);
            s1_last_reg  <= s_axis_tlast;
            s1_x_reg     <= in_value;
        end
        if (s1_to_s2)
        begin
            s2_last_reg <= s1_last_reg;
        end
        if (out_load)
        begin
            out_byte_reg <= y_out;
            out_last_reg <= last_out;
        end
    end

    // Key store: one write port, two read ports for the chain and position entries.
    always_ff @(posedge clk)
    begin
        if (key_wr)
        begin
            key_mem[POS_W'(in_addr)] <= in_value;
        end
        if (data_fire)
        begin
            key_chain_rd_reg <= key_mem[POS_W'(chain_reg)];
            key_pos_rd_reg   <= key_mem[pos_reg];
        end
    end

    // Substitution table: one write port and one shared read port.
    always_ff @(posedge clk)
    begin
        if (tab_wr)
        begin
            tab_mem[in_addr[BYTE_W-1:0]] <= in_value;
        end
        if (tab_rd_en)
        begin
            tab_rd_reg <= tab_mem[tab_rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // Only one encrypted byte is ever in the two cipher stages.
    a_one_enc_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && s2_valid_reg))
        else $error("both cipher stages hold a byte");

    // The second stage exists only for encryption.
    a_s2_encrypt_only: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> enc)
        else $error("second stage busy while decrypting");

    // A byte marked last restarts the position.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (data_fire && s_axis_tlast) |=> (pos_reg == '0))
        else $error("position not restarted after last byte");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !out_load)
        else $error("result register overwritten");

    // The position stays inside the key store.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(KEY_DEPTH))
        else $error("position beyond key depth");
`endif

endmodule

`default_nettype wire

// File: tb/chained_sbox_byte_cipher_top_tb.sv
// Self-checking testbench for the chained substitution byte cipher top level.
`default_nettype none

module chained_sbox_byte_cipher_top_tb;
    import chsbc_pkg::*;

    localparam int unsigned KEY_DEPTH     = 4096;
    localparam int unsigned KEY_FILL      = 256;
    localparam int unsigned RESET_CYCLES  = 6;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AFTER    = 100;
    localparam int unsigned LIMIT_CYCLES  = 2_000_000;
    localparam int unsigned PHASE_ITEMS   = 90;

    // One expected output transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } cipher_out_t;

    // Shadow of the cipher state, predicting each output byte from the accepted inputs.
    class cipher_scoreboard;
        logic [7:0]  key_mem [KEY_DEPTH];
        logic [7:0]  sub_mem [256];
        int unsigned pos;
        logic [7:0]  chain;
        mode_t       dir;
        cipher_out_t pending_bytes [$];
        int unsigned fails;
        int unsigned checked;
        int unsigned loads_seen;
        int unsigned ignored_seen;
        int unsigned wraps;

        function new();
            pos          = 0;
            chain        = 8'h00;
            dir          = MODE_ENCRYPT;
            fails        = 0;
            checked      = 0;
            loads_seen   = 0;
            ignored_seen = 0;
            wraps        = 0;
        endfunction

        // Adding 128 modulo 256 only flips the top bit, so the first-byte map is a
        // bit reversal framed by two top-bit flips.
        function logic [7:0] first_byte_map(input logic [7:0] v);
            logic [7:0] a;
            a = v ^ 8'h80;
            return {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7]} ^ 8'h80;
        endfunction

        // Update the shadow state for one accepted input transaction.
        function void note_item(input func_t f, input logic [11:0] a, input logic [7:0] v,
                                input logic l);
            logic [7:0] y;
            logic [7:0] ks;
            case (f)
                FUNC_KEY_LOAD:
                begin
                    if (a < KEY_DEPTH)
                    begin
                        key_mem[a] = v;
                    end
                    loads_seen++;
                end
                FUNC_TAB_LOAD:
                begin
                    sub_mem[a[7:0]] = v;
                    loads_seen++;
                end
                FUNC_DATA:
                begin
                    if (pos == 0)
                    begin
                        if (dir == MODE_ENCRYPT)
                            y = sub_mem[first_byte_map(v)];
                        else
                            y = first_byte_map(sub_mem[v]);
                    end
                    else
                    begin
                        ks = key_mem[chain] + key_mem[pos];
                        if (dir == MODE_ENCRYPT)
                            y = sub_mem[v ^ ks];
                        else
                            y = sub_mem[v] ^ ks;
                    end
                    chain = (dir == MODE_ENCRYPT) ? y : v;
                    if (l)
                    begin
                        pos = 0;
                    end
                    else if (pos == KEY_DEPTH - 1)
                    begin
                        pos = 0;
                        wraps++;
                    end
                    else
                    begin
                        pos = pos + 1;
                    end
                    pending_bytes.push_back('{out_byte: y, out_last: l});
                end
                default:
                begin
                    ignored_seen++;
                end
            endcase
        endfunction

        // Compare one accepted output transaction with the oldest expectation.
        function void check_byte(input logic [7:0] b, input logic l);
            cipher_out_t e;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected output transaction: out_byte %02h, out_last %0b", b, l);
                fails++;
                return;
            end
            e = pending_bytes.pop_front();
            checked++;
            if (b !== e.out_byte)
            begin
                $error("out_byte: expected %02h, actual %02h", e.out_byte, b);
                fails++;
            end
            if (l !== e.out_last)
            begin
                $error("out_last: expected %0b, actual %0b", e.out_last, l);
                fails++;
            end
        endfunction

        function int unsigned pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;

    cipher_scoreboard sb;
    int unsigned      cycle_count = 0;
    int unsigned      mode_writes = 0;
    int unsigned      longest_hold = 0;
    int unsigned      open_bytes = 0;
    bit               steady_feed = 1'b0;
    bit               held_once = 1'b0;

    chained_sbox_byte_cipher_top #(
        .KEY_DEPTH(KEY_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Random idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Offer one input transaction and wait until it is accepted; entered and left at a falling edge.
    task automatic send_item(input func_t f, input logic [11:0] a, input logic [7:0] v,
                             input logic l);
        s_axis_tdata  = {2'b00, v, a, f};
        s_axis_tlast  = l;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Sender gap between transactions.
    task automatic pause_sender();
        int unsigned n;
        n = steady_feed ? 0 : idle_len();
        if (n > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Send one transaction and keep count of the data bytes since the last marked byte.
    task automatic send_paced(input func_t f, input logic [11:0] a, input logic [7:0] v,
                              input logic l);
        send_item(f, a, v, l);
        if (f == FUNC_DATA)
        begin
            open_bytes = l ? 0 : open_bytes + 1;
        end
        pause_sender();
    endtask

    // Wait until every expected byte has arrived and any load has settled.
    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the mode register while the block is idle.
    task automatic set_mode(input mode_t m);
        cfg_wdata = m;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        sb.dir    = m;
        mode_writes++;
    endtask

    // One random phase: mostly whole messages with random content, mixed with loads,
    // unused codes and messages that stop without a last byte. A message is closed
    // before its position leaves the filled part of the key store.
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned r;
        int unsigned len;
        bit          broken;
        logic        last_flag;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                send_paced(FUNC_UNUSED, 12'($urandom), 8'($urandom), 1'($urandom));
            end
            else if (r < 14)
            begin
                send_paced(FUNC_KEY_LOAD, 12'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
            else if (r < 22)
            begin
                send_paced(FUNC_TAB_LOAD, 12'($urandom), 8'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(1, 8);
                else if (r < 95)
                    len = $urandom_range(9, 30);
                else
                    len = $urandom_range(31, 120);
                broken = ($urandom_range(0, 9) == 0);
                for (int unsigned i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send_paced(func_t'($urandom_range(0, 1)), 12'($urandom),
                                   8'($urandom), 1'($urandom));
                        sent++;
                    end
                    last_flag = ((i == len - 1) && !broken) || (open_bytes >= KEY_FILL - 1);
                    send_paced(FUNC_DATA, 12'($urandom), 8'($urandom), last_flag);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls, long ready runs, and one long hold-off to fill the block.
    initial
    begin
        int unsigned n;
        int unsigned held;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held_once && sb.checked >= HOLD_AFTER && s_axis_tvalid)
            begin
                m_axis_tready = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                held_once    = 1'b1;
                longest_hold = held;
            end
            n = idle_len();
            if (n > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(50, 150);
            repeat (n) @(negedge clk);
        end
    end

    // Monitor: check accepted outputs, then note accepted inputs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_byte(m_axis_tdata, m_axis_tlast);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_item(func_t'(s_axis_tdata[1:0]), s_axis_tdata[13:2],
                             s_axis_tdata[21:14], s_axis_tlast);
            end
        end
    end

    // Cycle limit.
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("chained_sbox_byte_cipher_top regression: fail");
        $finish;
    end

    // Main sequence.
    initial
    begin
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill the table and the low key entries. Chain bytes and positions stay below
        // KEY_FILL, so no later read hits an unwritten entry.
        steady_feed = 1'b1;
        for (int unsigned i = 0; i < 256; i++)
        begin
            send_paced(FUNC_TAB_LOAD, 12'(i), 8'($urandom), 1'b0);
        end
        for (int unsigned i = 0; i < KEY_FILL; i++)
        begin
            send_paced(FUNC_KEY_LOAD, 12'(i), 8'($urandom), 1'b0);
        end
        steady_feed = 1'b0;

        // Directed: field extremes, address wrap of table loads, unused code, mode change
        // in the middle of a message.
        send_paced(FUNC_KEY_LOAD, 12'hFFF, 8'hFF, 1'b1);
        send_paced(FUNC_KEY_LOAD, 12'h000, 8'h00, 1'b0);
        send_paced(FUNC_TAB_LOAD, 12'hFFF, 8'hAA, 1'b0);
        send_paced(FUNC_TAB_LOAD, 12'h100, 8'h00, 1'b1);
        send_paced(FUNC_UNUSED, 12'hFFF, 8'hFF, 1'b1);
        send_paced(FUNC_DATA, 12'h000, 8'h00, 1'b1);
        send_paced(FUNC_DATA, 12'hFFF, 8'h00, 1'b0);
        send_paced(FUNC_DATA, 12'h000, 8'hFF, 1'b0);
        send_paced(FUNC_DATA, 12'hFFF, 8'h80, 1'b0);
        wait_idle();
        set_mode(MODE_DECRYPT);
        send_paced(FUNC_DATA, 12'h000, 8'h7F, 1'b0);
        send_paced(FUNC_DATA, 12'hFFF, 8'h01, 1'b1);
        send_paced(FUNC_DATA, 12'h000, 8'hFF, 1'b0);
        send_paced(FUNC_DATA, 12'h000, 8'h00, 1'b1);
        send_paced(FUNC_UNUSED, 12'h000, 8'h00, 1'b0);
        wait_idle();

        // Random phases, alternating the mode; one of them without sender gaps.
        for (int unsigned p = 0; p < 4; p++)
        begin
            set_mode((p % 2 == 0) ? MODE_ENCRYPT : MODE_DECRYPT);
            steady_feed = (p == 2);
            run_random_phase(PHASE_ITEMS);
            wait_idle();
        end
        steady_feed = 1'b0;

        if (sb.pending() != 0)
        begin
            $error("%0d expected output transactions never arrived", sb.pending());
            sb.fails++;
        end

        $display("Checked %0d output bytes; %0d loads and %0d unused-code transactions taken.",
                 sb.checked, sb.loads_seen, sb.ignored_seen);
        $display("%0d mode writes, %0d position wraps, receiver hold-off of %0d cycles.",
                 mode_writes, sb.wraps, longest_hold);
        if (sb.fails == 0)
        begin
            $display("chained_sbox_byte_cipher_top regression: pass");
        end
        else
        begin
            $display("chained_sbox_byte_cipher_top regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
